/* design/cspmv_pkg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// CSR SpMV package
// Types, constants and item codes shared by the sparse matrix-vector blocks.
// -----------------------------------------------------------------------------
package cspmv_pkg;

   localparam int VECTOR_DEPTH = 1024;
   localparam int VEC_ADDR_W   = $clog2(VECTOR_DEPTH);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);

   localparam int KIND_W   = 2;
   localparam int COLUMN_W = 10;
   localparam int VALUE_W  = 32;
   localparam int ROW_W    = 16;
   localparam int SUM_W    = 64;
   localparam int FRAC_W   = 16;

   localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_NONZERO = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_ACCUM,
      OP_ACCUM_EMIT,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic signed [VALUE_W-1:0]  value;
      logic signed [VALUE_W-1:0]  x;
   } work_type;

   typedef struct packed {
      logic busy;
      logic hand_off;
   } front_status_type;

   typedef struct packed {
      logic emit_fire;
      logic accum_fire;
   } back_status_type;

endpackage

/* design/csr_sparse_matrix_vector_multiply.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// CSR sparse matrix-vector multiply
// Streams vector loads and CSR nonzeros, emits saturated Q48.16 row sums.
// -----------------------------------------------------------------------------
// The block sustains one item per clock cycle while the result channel does
// not stall: the vector store has one read or write per cycle and a single 32
// by 32 multiplier takes one nonzero per cycle. A row sum passes through the
// front register, the queue, the product register and the output register,
// in that order, before it appears on the result channel.
// The vector store has no reset and no clearing pass; a nonzero whose column
// was never loaded yields an undefined sum.
// Write row_count only while no items are in flight.
module csr_sparse_matrix_vector_multiply import cspmv_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [47:0]       req_tdata,    // column_index[9:0], item_value[41:10], zero pad
   input  logic [KIND_W-1:0] req_tuser,    // kind[1:0]
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [79:0]       rsp_tdata,    // row_index[15:0], row_sum[79:16]
   output logic              rsp_tlast,
   input  logic              csr_wr_en,
   input  logic [ROW_W-1:0]  csr_wr_data
);

   logic [ROW_W-1:0]         row_count_ff;
   logic                     work_valid;
   logic                     work_ready;
   work_type                 front_work;
   logic                     q_valid;
   logic                     q_ready;
   work_type                 q_work;
   front_status_type         front_status;
   back_status_type          back_status;
   logic [ROW_W-1:0]         row_index;
   logic signed [SUM_W-1:0]  row_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= ROW_W'(1);
      end else if (csr_wr_en) begin
         row_count_ff <= csr_wr_data;
      end
   end

   cspmv_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .kind         (req_tuser),
      .column_index (req_tdata[COLUMN_W-1:0]),
      .item_value   (req_tdata[COLUMN_W+VALUE_W-1:COLUMN_W]),
      .ends_row     (req_tlast),
      .work_valid   (work_valid),
      .work_ready   (work_ready),
      .work         (front_work),
      .status       (front_status)
   );

   cspmv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (work_valid),
      .in_ready  (work_ready),
      .in_work   (front_work),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_work  (q_work)
   );

   cspmv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work_valid (q_valid),
      .work_ready (q_ready),
      .work       (q_work),
      .row_count  (row_count_ff),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .row_index  (row_index),
      .row_sum    (row_sum),
      .last_row   (rsp_tlast),
      .status     (back_status)
   );

   assign rsp_tdata = {row_sum, row_index};

`ifndef SYNTH
   a_work_enters_front: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == KIND_NONZERO || req_tuser == KIND_EMPTY)
      |=> front_status.busy)
      else $error("accepted nonzero or empty-row item did not reach the front register");

   a_load_not_forwarded: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser != KIND_NONZERO && req_tuser != KIND_EMPTY
      |=> !front_status.busy)
      else $error("load or unused item was forwarded to the back end");

   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(back_status.emit_fire))
      else $error("result appeared without a row emit in the back end");

   a_single_back_action: assert property (@(posedge clock) disable iff (reset)
      !(back_status.emit_fire && back_status.accum_fire))
      else $error("back end accumulated and emitted in the same cycle");
`endif

endmodule

/* design/cspmv_front.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// CSR SpMV front end
// Accepts items, keeps the vector store and fetches the entry for each nonzero.
// -----------------------------------------------------------------------------
module cspmv_front import cspmv_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [KIND_W-1:0]          kind,
   input  logic [COLUMN_W-1:0]        column_index,
   input  logic signed [VALUE_W-1:0]  item_value,
   input  logic                       ends_row,
   output logic                       work_valid,
   input  logic                       work_ready,
   output work_type                   work,
   output front_status_type           status
);

   logic [VALUE_W-1:0]         vector_mem [VECTOR_DEPTH];
   logic [VEC_ADDR_W-1:0]      addr;
   logic                       accept;
   logic                       mem_we;
   logic                       mem_re;
   logic                       is_work;
   op_type                     op_dec;

   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   op_type                     s1_op_ff;
   logic signed [VALUE_W-1:0]  s1_value_ff;
   logic signed [VALUE_W-1:0]  x_ff;

   assign addr      = column_index[VEC_ADDR_W-1:0];
   assign req_ready = !s1_valid_ff || work_ready;
   assign accept    = req_valid && req_ready;
   assign mem_we    = accept && (kind == KIND_LOAD);
   assign mem_re    = accept && (kind == KIND_NONZERO);

   always_comb begin
      is_work = 1'b0;
      op_dec  = OP_EMIT;
      unique case (kind)
         KIND_NONZERO: begin
            is_work = 1'b1;
            op_dec  = ends_row ? OP_ACCUM_EMIT : OP_ACCUM;
         end
         KIND_EMPTY: begin
            is_work = 1'b1;
            op_dec  = OP_EMIT;
         end
         default: begin
            is_work = 1'b0;
            op_dec  = OP_EMIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         vector_mem[addr] <= item_value;
      end
      if (mem_re) begin
         x_ff <= vector_mem[addr];
      end
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = is_work;
      end else if (work_ready) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= op_dec;
         s1_value_ff <= item_value;
      end
   end

   assign work_valid      = s1_valid_ff;
   assign work.op         = s1_op_ff;
   assign work.value      = s1_value_ff;
   assign work.x          = x_ff;
   assign status.busy     = s1_valid_ff;
   assign status.hand_off = s1_valid_ff && work_ready;

endmodule

/* design/cspmv_queue.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// CSR SpMV work queue
// Short first-in first-out buffer between the front end and the back end.
// -----------------------------------------------------------------------------
module cspmv_queue import cspmv_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  work_type  in_work,
   output logic      out_valid,
   input  logic      out_ready,
   output work_type  out_work
);

   work_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]    wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]    rd_ptr_ff;
   logic [QUEUE_PTR_W:0]      count_ff;
   logic [QUEUE_PTR_W:0]      count_in;
   logic                      push;
   logic                      pop;

   assign in_ready  = count_ff != (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_work  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_work;
      end
   end

endmodule

/* design/cspmv_back.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// CSR SpMV back end
// Multiplies, accumulates with saturation and emits completed row sums.
// -----------------------------------------------------------------------------
module cspmv_back import cspmv_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       work_valid,
   output logic                       work_ready,
   input  work_type                   work,
   input  logic [ROW_W-1:0]           row_count,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [ROW_W-1:0]           row_index,
   output logic signed [SUM_W-1:0]    row_sum,
   output logic                       last_row,
   output back_status_type            status
);

   logic                      m_valid_ff;
   logic                      m_valid_in;
   op_type                    m_op_ff;
   logic signed [SUM_W-1:0]   m_prod_ff;
   logic signed [SUM_W-1:0]   prod_in;

   logic signed [SUM_W-1:0]   acc_ff;
   logic signed [SUM_W-1:0]   acc_in;
   logic signed [SUM_W-1:0]   addend;
   logic signed [SUM_W-1:0]   sum;
   logic signed [SUM_W-1:0]   acc_new;
   logic                      overflow;
   logic [ROW_W-1:0]          row_ff;
   logic [ROW_W-1:0]          row_in;
   logic                      is_last;

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [ROW_W-1:0]          rsp_row_ff;
   logic signed [SUM_W-1:0]   rsp_sum_ff;
   logic                      rsp_last_ff;

   logic                      m_emit;
   logic                      out_free;
   logic                      m_adv;
   logic                      take;

   assign m_emit     = m_op_ff != OP_ACCUM;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign m_adv      = m_valid_ff && (!m_emit || out_free);
   assign work_ready = !m_valid_ff || m_adv;
   assign take       = work_valid && work_ready;

   assign prod_in = SUM_W'({{(SUM_W-VALUE_W){work.value[VALUE_W-1]}}, work.value}
                         * {{(SUM_W-VALUE_W){work.x[VALUE_W-1]}}, work.x});

   always_comb begin
      if (take) begin
         m_valid_in = 1'b1;
      end else if (m_adv) begin
         m_valid_in = 1'b0;
      end else begin
         m_valid_in = m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         m_op_ff   <= work.op;
         m_prod_ff <= prod_in;
      end
   end

   assign addend   = (m_op_ff == OP_EMIT) ? '0
                   : {{FRAC_W{m_prod_ff[SUM_W-1]}}, m_prod_ff[SUM_W-1:FRAC_W]};
   assign sum      = acc_ff + addend;
   assign overflow = (acc_ff[SUM_W-1] == addend[SUM_W-1]) &&
                     (sum[SUM_W-1] != acc_ff[SUM_W-1]);
   assign acc_new  = overflow ? (acc_ff[SUM_W-1] ? SUM_MIN : SUM_MAX) : sum;
   assign is_last  = ({1'b0, row_ff} + (ROW_W+1)'(1)) >= {1'b0, row_count};

   always_comb begin
      acc_in = acc_ff;
      row_in = row_ff;
      if (m_adv) begin
         if (m_emit) begin
            acc_in = '0;
            row_in = is_last ? '0 : row_ff + 1'b1;
         end else begin
            acc_in = acc_new;
         end
      end
   end

   always_comb begin
      if (m_adv && m_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         acc_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         m_valid_ff   <= m_valid_in;
         acc_ff       <= acc_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (m_adv && m_emit) begin
         rsp_row_ff  <= row_ff;
         rsp_sum_ff  <= acc_new;
         rsp_last_ff <= is_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign row_index         = rsp_row_ff;
   assign row_sum           = rsp_sum_ff;
   assign last_row          = rsp_last_ff;
   assign status.emit_fire  = m_adv && m_emit;
   assign status.accum_fire = m_adv && !m_emit;

endmodule

/* dv/tb_csr_sparse_matrix_vector_multiply.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Testbench for the CSR sparse matrix-vector multiply
// Streams vector loads, nonzeros and empty rows into the block with random
// gaps and back-pressure. A scoreboard keeps its own vector store, row sum
// and row counter, predicts every row sum and checks each result in order.
// Also covers several row_count values.
// -----------------------------------------------------------------------------
module tb_csr_sparse_matrix_vector_multiply;
   import cspmv_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 550;
   localparam int CYCLE_LIMIT  = 200_000;

   typedef struct {
      logic [ROW_W-1:0]        row;
      logic signed [SUM_W-1:0] sum;
      logic                    last;
   } row_result_type;

   class spmv_scoreboard;
      logic signed [VALUE_W-1:0] vec [VECTOR_DEPTH];
      logic signed [SUM_W-1:0]   row_sum;
      logic [ROW_W-1:0]          row_now;
      logic [ROW_W-1:0]          row_count;
      row_result_type            rows_due [$];
      int                        errors;

      function new();
         row_sum   = '0;
         row_now   = '0;
         row_count = 16'd1;
         errors    = 0;
      endfunction

      function int pending();
         return rows_due.size();
      endfunction

      task report(input string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      function void close_row();
         row_result_type r;
         r.row  = row_now;
         r.sum  = row_sum;
         r.last = (32'(row_now) + 1) >= 32'(row_count);
         rows_due.push_back(r);
         row_sum = '0;
         row_now = r.last ? '0 : row_now + 1'b1;
      endfunction

      function void apply_item(input logic [KIND_W-1:0] kind, input logic [COLUMN_W-1:0] col,
                               input logic [VALUE_W-1:0] value, input logic ends);
         longint a, b, prod;
         logic signed [SUM_W-1:0] d, s;
         case (kind)
            KIND_LOAD: vec[col] = value;
            KIND_NONZERO: begin
               a = $signed(value);
               b = vec[col];
               prod = a * b;
               d = prod >>> FRAC_W;
               s = row_sum + d;
               if (row_sum[SUM_W-1] == d[SUM_W-1] && s[SUM_W-1] != row_sum[SUM_W-1])
                  s = row_sum[SUM_W-1] ? SUM_MIN : SUM_MAX;
               row_sum = s;
               if (ends) close_row();
            end
            KIND_EMPTY: close_row();
            default: ;
         endcase
      endfunction

      task check_row(input logic [ROW_W-1:0] row, input logic signed [SUM_W-1:0] sum,
                     input logic last);
         row_result_type r;
         if (rows_due.size() == 0) begin
            report($sformatf("unexpected row %0d sum %0d", row, sum));
         end else begin
            r = rows_due.pop_front();
            if (row !== r.row)
               report($sformatf("row_index %0d, expected %0d", row, r.row));
            if (sum !== r.sum)
               report($sformatf("row %0d row_sum %0d, expected %0d", r.row, sum, r.sum));
            if (last !== r.last)
               report($sformatf("row %0d last_row %0b, expected %0b", r.row, last, r.last));
         end
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [47:0]         req_tdata = '0;   // column_index[9:0], item_value[41:10], zero pad
   logic [KIND_W-1:0]   req_tuser = '0;   // kind[1:0]
   logic                req_tlast = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [79:0]         rsp_tdata;        // row_index[15:0], row_sum[79:16]
   logic                rsp_tlast;
   logic                csr_wr_en = 1'b0;
   logic [ROW_W-1:0]    csr_wr_data = '0;

   spmv_scoreboard sb = new();
   bit             idle_on = 1'b1;
   bit             hold_now = 1'b0;
   int             items_sent = 0;
   int             cycle_count = 0;
   int             loaded_cols [$];
   bit             col_loaded [VECTOR_DEPTH];

   csr_sparse_matrix_vector_multiply DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic [ROW_W-1:0] pick_row_count();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 16'hFFFF;
         2: return ROW_W'($urandom_range(0, 65535));
         default: return ROW_W'($urandom_range(1, 6));
      endcase
   endfunction

   function automatic logic [COLUMN_W-1:0] loaded_col();
      return COLUMN_W'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]);
   endfunction

   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [COLUMN_W-1:0] col,
                            input logic [VALUE_W-1:0] value, input logic ends);
      int gap;
      gap = idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'd0, value, col};
      req_tlast  <= ends;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.apply_item(kind, col, value, ends);
      if (kind == KIND_LOAD && !col_loaded[col]) begin
         col_loaded[col] = 1'b1;
         loaded_cols.push_back(int'(col));
      end
      if (kind != KIND_UNUSED) items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_row_count(input logic [ROW_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.row_count = value;
   endtask

   task automatic send_row(input bit partial);
      int n;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
         send_item(KIND_NONZERO, loaded_col(), $urandom, !partial && (i == n - 1));
      if (partial) send_item(KIND_EMPTY, COLUMN_W'($urandom), $urandom, 1'($urandom));
   endtask

   initial begin : result_side
      int stall_left;
      bit held;
      stall_left = 0;
      held       = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            sb.check_row(rsp_tdata[15:0], rsp_tdata[79:16], rsp_tlast);
         end
         if (!held && hold_now) begin
            held = 1'b1;
            stall_left = 300;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_on) stall_left = pick_gap();
         end
      end
   end

   initial begin : stimulus
      int start;
      int rows;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_row_count(16'd3);
      send_item(KIND_LOAD,    10'd0,    32'h7FFF_FFFF, 1'b1);
      send_item(KIND_LOAD,    10'd1023, 32'h8000_0000, 1'b0);
      send_item(KIND_LOAD,    10'd1,    32'hFFFF_FFFF, 1'b0);
      send_item(KIND_LOAD,    10'd512,  32'h0001_0000, 1'b0);
      send_item(KIND_NONZERO, 10'd0,    32'h8000_0000, 1'b0);
      send_item(KIND_NONZERO, 10'd1023, 32'h8000_0000, 1'b0);
      send_item(KIND_NONZERO, 10'd1,    32'h0000_0001, 1'b1);
      send_item(KIND_EMPTY,   10'd1023, 32'h0000_0000, 1'b1);
      send_item(KIND_UNUSED,  10'd1023, 32'hFFFF_FFFF, 1'b1);
      send_item(KIND_NONZERO, 10'd512,  32'h7FFF_FFFF, 1'b1);
      send_item(KIND_NONZERO, 10'd1,    32'hFFFF_FFFF, 1'b0);
      send_item(KIND_EMPTY,   10'd0,    32'h0000_0000, 1'b0);
      send_item(KIND_NONZERO, 10'd0,    32'h0000_0000, 1'b1);
      send_item(KIND_NONZERO, 10'd512,  32'h8000_0000, 1'b0);
      send_item(KIND_NONZERO, 10'd1,    32'h0000_0000, 1'b1);
      drain();
      write_row_count(16'd0);
      send_item(KIND_EMPTY, 10'd5, 32'h1234_5678, 1'b0);
      drain();

      write_row_count(16'hFFFF);
      for (int i = 0; i < 5; i++)
         send_item(KIND_EMPTY, COLUMN_W'($urandom), $urandom, 1'($urandom));
      drain();
      write_row_count(16'd2);
      send_row(1'b0);

      // The result side holds off for a long stretch while rows keep coming.
      hold_now = 1'b1;
      for (int i = 0; i < 10; i++) send_row(1'b0);
      hold_now = 1'b0;

      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            drain();
            write_row_count(pick_row_count());
         end
         idle_on = ($urandom_range(0, 3) != 0);
         rows = $urandom_range(1, 6);
         for (int r = 0; r < rows; r++) begin
            if ($urandom_range(0, 3) == 0)
               send_item(KIND_LOAD, COLUMN_W'($urandom), $urandom, 1'($urandom));
            if ($urandom_range(0, 19) == 0)
               send_item(KIND_UNUSED, COLUMN_W'($urandom), $urandom, 1'($urandom));
            case ($urandom_range(0, 9))
               0: send_item(KIND_EMPTY, COLUMN_W'($urandom), $urandom, 1'($urandom));
               1: send_row(1'b1);
               default: send_row(1'b0);
            endcase
         end
      end
      idle_on = 1'b1;

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
